FILE: hdl/spm_pkg.sv
// Shared types, register offsets and helpers for the serial master port.
// Used by every module of the port; depends on nothing.
`default_nettype none

package spm_pkg;

    localparam int FIFO_DEPTH_DEF = 8;
    localparam int WORD_W         = 16;

    localparam logic [31:0] SYS_CLOCK_RESET = 32'd125000000;
    localparam logic [31:0] SPI_CLOCK_RESET = 32'd125000000;

    // Configuration register indexes
    localparam logic CFG_SYS_CLOCK = 1'b0;
    localparam logic CFG_SPI_CLOCK = 1'b1;

    // Item modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Register byte offsets
    localparam logic [11:0] OFF_CR0   = 12'h000;
    localparam logic [11:0] OFF_CR1   = 12'h004;
    localparam logic [11:0] OFF_DR    = 12'h008;
    localparam logic [11:0] OFF_SR    = 12'h00C;
    localparam logic [11:0] OFF_CPSR  = 12'h010;
    localparam logic [11:0] OFF_IMSC  = 12'h014;
    localparam logic [11:0] OFF_RIS   = 12'h018;
    localparam logic [11:0] OFF_MIS   = 12'h01C;
    localparam logic [11:0] OFF_DMACR = 12'h024;

    // Status register bits
    localparam int SR_TFE = 0;
    localparam int SR_TNF = 1;
    localparam int SR_RNE = 2;
    localparam int SR_RFF = 3;
    localparam int SR_BSY = 4;

    // Raw interrupt bits
    localparam int RIS_RX = 2;
    localparam int RIS_TX = 3;

    // CR1 bits
    localparam int CR1_LBM = 0;
    localparam int CR1_SSE = 1;

    // DMACR bits
    localparam int DMA_RX = 0;
    localparam int DMA_TX = 1;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_READ,
        CMD_WRITE,
        CMD_TICK
    } spm_kind_t;

    typedef enum logic [3:0] {
        REG_NONE,
        REG_CR0,
        REG_CR1,
        REG_DR,
        REG_SR,
        REG_CPSR,
        REG_IMSC,
        REG_RIS,
        REG_MIS,
        REG_DMACR
    } spm_reg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] offset;
        logic [31:0] write_value;
        logic [15:0] miso_word;
        logic        miso_valid;
    } spm_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        mosi_valid;
        logic [7:0]  mosi_byte;
        logic        irq_pending;
        logic        tx_dma_request;
        logic        rx_dma_request;
    } spm_out_t;

    typedef struct packed {
        spm_kind_t   kind;
        spm_reg_t    regsel;
        logic [31:0] wdata;
        logic [15:0] miso_word;
        logic        miso_valid;
    } spm_cmd_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [WORD_W-1:0] push_data;
    } spm_fifo_ctl_t;

    // Mask of a frame of (dss + 1) bits
    function automatic logic [WORD_W-1:0] frame_mask(input logic [3:0] dss);
        logic [3:0] sh;
        sh = 4'hF - dss;
        return {WORD_W{1'b1}} >> sh;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/spi_master_port_with_fifos_core.sv
// Top level of the synchronous serial master port with transmit and receive FIFOs.
// Depends on spm_pkg, spm_front, spm_cmd_q, spm_back (and spm_fifo below it).
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_ready  | in_item  (spm_in_t: mode, offset, data,
//           |                      |           miso_word, miso_valid)
//   out     | out_valid / out_ready| out_item (spm_out_t: read_data, mosi,
//           |                      |           irq and DMA requests)
//   cfg     | cfg_write            | cfg_index, cfg_data (no read-back)
//
// One request is accepted per cycle while the queue has room, and one result
// leaves per cycle while out_ready is high. A request is classified into the
// queue at its accepting edge and executed into the output register once it
// heads the queue and that register is free or being taken. The back end
// executes one queued operation per cycle against the register state, under
// the same condition. A stalled output holds its register; the two-entry
// operation queue absorbs the stall so in_ready drops only when the queue is
// full. Reset is asynchronous, clears all control and architectural state, and
// needs no clearing pass: FIFO contents are only read after being written.
`default_nettype none

module spi_master_port_with_fifos_core #(
    parameter int FIFO_DEPTH = spm_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_write,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  spm_pkg::spm_in_t  in_item,
    output logic              out_valid,
    input  wire logic         out_ready,
    output spm_pkg::spm_out_t out_item
);
    import spm_pkg::*;

    spm_cmd_t front_cmd;
    spm_cmd_t head_cmd;
    logic     q_can_push;
    logic     q_can_pop;
    logic     q_pop;

    // Classify: map mode and offset to an operation kind and register select
    spm_front u_front (
        .in_item (in_item),
        .cmd     (front_cmd)
    );

    // Decouple: accept whenever the queue has room, independent of the output side
    spm_cmd_q u_cmd_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid),
        .push_cmd (front_cmd),
        .can_push (q_can_push),
        .pop      (q_pop),
        .can_pop  (q_can_pop),
        .head_cmd (head_cmd)
    );

    assign in_ready = q_can_push;

    // Execute: advance registers, rate generator, shifter and FIFOs; hold result
    spm_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (q_can_pop),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

FILE: hdl/spm_front.sv
// Front end: classify an incoming item into an operation kind and register select.
// Depends on spm_pkg.
`default_nettype none

module spm_front (
    input  spm_pkg::spm_in_t  in_item,
    output spm_pkg::spm_cmd_t cmd
);
    import spm_pkg::*;

    spm_kind_t kind;
    spm_reg_t  regsel;

    always_comb
    begin
        unique case (in_item.mode)
            MODE_READ:  kind = CMD_READ;
            MODE_WRITE: kind = CMD_WRITE;
            MODE_TICK:  kind = CMD_TICK;
            default:    kind = CMD_NOP;
        endcase
    end

    // Unaligned or unknown offsets fall to REG_NONE
    always_comb
    begin
        unique case (in_item.offset)
            OFF_CR0:   regsel = REG_CR0;
            OFF_CR1:   regsel = REG_CR1;
            OFF_DR:    regsel = REG_DR;
            OFF_SR:    regsel = REG_SR;
            OFF_CPSR:  regsel = REG_CPSR;
            OFF_IMSC:  regsel = REG_IMSC;
            OFF_RIS:   regsel = REG_RIS;
            OFF_MIS:   regsel = REG_MIS;
            OFF_DMACR: regsel = REG_DMACR;
            default:   regsel = REG_NONE;
        endcase
    end

    assign cmd.kind       = kind;
    assign cmd.regsel     = regsel;
    assign cmd.wdata      = in_item.write_value;
    assign cmd.miso_word  = in_item.miso_word;
    assign cmd.miso_valid = in_item.miso_valid;

endmodule

`default_nettype wire

FILE: hdl/spm_cmd_q.sv
// Two-entry queue of classified operations between front and back.
// Depends on spm_pkg.
`default_nettype none

module spm_cmd_q (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  spm_pkg::spm_cmd_t push_cmd,
    output logic              can_push,
    input  wire logic         pop,
    output logic              can_pop,
    output spm_pkg::spm_cmd_t head_cmd
);
    import spm_pkg::*;

    spm_cmd_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign can_push = (count_reg != 2'd2);
    assign can_pop  = (count_reg != 2'd0);
    assign do_push  = push && can_push;
    assign do_pop   = pop && can_pop;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/spm_fifo.sv
// Data FIFO on a synchronous memory with a registered, bypassed head word.
// Depends on spm_pkg.
`default_nettype none

module spm_fifo #(
    parameter int DEPTH = spm_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  spm_pkg::spm_fifo_ctl_t        ctl,
    output logic [spm_pkg::WORD_W-1:0]    head_data,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import spm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] head_data_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              wr;
    logic              rd;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr = ctl.push && (count_reg != CNT_W'(DEPTH));
    assign rd = ctl.pop && (count_reg != '0);

    always_comb
    begin
        head_next  = rd ? ptr_inc(head_reg) : head_reg;
        tail_next  = wr ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[tail_reg] <= ctl.push_data;
    end

    // Prefetch the word at the next head; forward a write that lands there
    always_ff @(posedge clk)
    begin
        if (wr && (tail_reg == head_next))
            head_data_reg <= ctl.push_data;
        else
            head_data_reg <= mem[head_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign head_data = head_data_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

FILE: hdl/spm_back.sv
// Back end: register file, rate accumulator, bit-rate generator, shifter and FIFOs.
// Executes one queued operation per cycle while its output is free. Depends on spm_pkg, spm_fifo.
`default_nettype none

module spm_back #(
    parameter int FIFO_DEPTH = spm_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_write,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         cmd_valid,
    input  spm_pkg::spm_cmd_t cmd,
    output logic              cmd_pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output spm_pkg::spm_out_t out_item
);
    import spm_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [31:0]       sys_hz_reg;
    logic [31:0]       spi_hz_reg;
    logic [31:0]       add_amt_reg;
    logic [31:0]       cr0_reg;
    logic [31:0]       cr0_next;
    logic [31:0]       cr1_reg;
    logic [31:0]       cr1_next;
    logic [7:0]        cpsr_reg;
    logic [7:0]        cpsr_next;
    logic [3:0]        imsc_reg;
    logic [3:0]        imsc_next;
    logic [1:0]        dmacr_reg;
    logic [1:0]        dmacr_next;
    logic [32:0]       accum_reg;
    logic [32:0]       accum_next;
    logic [15:0]       bitcnt_reg;
    logic [15:0]       bitcnt_next;
    logic [4:0]        bits_rem_reg;
    logic [4:0]        bits_rem_next;
    logic [15:0]       shift_reg;
    logic [15:0]       shift_next;
    logic              out_valid_reg;
    spm_out_t          out_item_reg;
    spm_out_t          out_next;

    spm_fifo_ctl_t     tx_ctl;
    spm_fifo_ctl_t     rx_ctl;
    logic [WORD_W-1:0] tx_head;
    logic [WORD_W-1:0] rx_head;
    logic [CNT_W-1:0]  tx_count;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  tx_cnt_next;
    logic [CNT_W-1:0]  rx_cnt_next;

    logic              exec;
    logic              enabled;
    logic              tx_full;
    logic              tx_empty;
    logic              rx_full;
    logic              rx_empty;
    logic [WORD_W-1:0] mask;
    logic [8:0]        scr_p1;
    logic [16:0]       period;
    logic              gen_on;
    logic [33:0]       sum;
    logic              per_tick;
    logic [15:0]       bitcnt_inc;
    logic              bit_step;
    logic [4:0]        status;
    logic [3:0]        raw;
    logic [15:0]       capture;

    assign exec     = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_pop  = exec;
    assign enabled  = cr1_reg[CR1_SSE];
    assign tx_full  = (tx_count == CNT_W'(FIFO_DEPTH));
    assign tx_empty = (tx_count == '0);
    assign rx_full  = (rx_count == CNT_W'(FIFO_DEPTH));
    assign rx_empty = (rx_count == '0);
    assign mask     = frame_mask(cr0_reg[3:0]);

    // Bit period in peripheral ticks; generator runs only for even prescale >= 2
    assign scr_p1 = {1'b0, cr0_reg[15:8]} + 9'd1;
    assign period = {9'd0, cpsr_reg} * {8'd0, scr_p1};
    assign gen_on = !cpsr_reg[0] && (cpsr_reg[7:1] != 7'd0);

    assign sum        = {1'b0, accum_reg} + {2'b00, add_amt_reg};
    assign per_tick   = enabled && (sys_hz_reg != 32'd0) && (sum >= {2'b00, sys_hz_reg});
    assign bitcnt_inc = bitcnt_reg + 16'd1;
    assign bit_step   = per_tick && gen_on && ({1'b0, bitcnt_inc} >= period);

    always_comb
    begin
        status         = '0;
        status[SR_TFE] = tx_empty;
        status[SR_TNF] = !tx_full;
        status[SR_RNE] = !rx_empty;
        status[SR_RFF] = rx_full;
        status[SR_BSY] = !tx_empty || (bits_rem_reg != 5'd0);
        raw            = '0;
        raw[RIS_TX]    = enabled && !tx_full;
        raw[RIS_RX]    = enabled && !rx_empty;
    end

    always_comb
    begin
        if (cr1_reg[CR1_LBM])
            capture = shift_reg;
        else if (cmd.miso_valid)
            capture = cmd.miso_word;
        else
            capture = 16'hFFFF;
    end

    always_comb
    begin
        cr0_next      = cr0_reg;
        cr1_next      = cr1_reg;
        cpsr_next     = cpsr_reg;
        imsc_next     = imsc_reg;
        dmacr_next    = dmacr_reg;
        accum_next    = accum_reg;
        bitcnt_next   = bitcnt_reg;
        bits_rem_next = bits_rem_reg;
        shift_next    = shift_reg;
        tx_ctl        = '0;
        rx_ctl        = '0;
        out_next      = '0;

        if (exec)
        begin
            case (cmd.kind)
                CMD_READ:
                begin
                    case (cmd.regsel)
                        REG_CR0:   out_next.read_data = cr0_reg;
                        REG_CR1:   out_next.read_data = cr1_reg;
                        REG_DR:
                        begin
                            // Pop the receive head; empty reads give zero
                            if (!rx_empty)
                            begin
                                out_next.read_data = {16'd0, rx_head};
                                rx_ctl.pop         = 1'b1;
                            end
                        end
                        REG_SR:    out_next.read_data = {27'd0, status};
                        REG_CPSR:  out_next.read_data = {24'd0, cpsr_reg};
                        REG_IMSC:  out_next.read_data = {28'd0, imsc_reg};
                        REG_RIS:   out_next.read_data = {28'd0, raw};
                        REG_MIS:   out_next.read_data = {28'd0, raw & imsc_reg};
                        REG_DMACR: out_next.read_data = {30'd0, dmacr_reg};
                        default:   out_next.read_data = '0;
                    endcase
                end
                CMD_WRITE:
                begin
                    case (cmd.regsel)
                        REG_CR0:   cr0_next   = cmd.wdata;
                        REG_CR1:   cr1_next   = cmd.wdata;
                        REG_DR:
                        begin
                            tx_ctl.push      = 1'b1;
                            tx_ctl.push_data = cmd.wdata[15:0] & mask;
                        end
                        REG_CPSR:  cpsr_next  = cmd.wdata[7:0];
                        REG_IMSC:  imsc_next  = cmd.wdata[3:0];
                        REG_DMACR: dmacr_next = cmd.wdata[1:0];
                        default:   cr0_next   = cr0_reg;
                    endcase
                end
                CMD_TICK:
                begin
                    if (enabled && (sys_hz_reg != 32'd0))
                    begin
                        if (per_tick)
                            accum_next = 33'(sum - {2'b00, sys_hz_reg});
                        else
                            accum_next = sum[32:0];
                        if (per_tick && gen_on)
                            bitcnt_next = bit_step ? 16'd0 : bitcnt_inc;
                        if (bit_step)
                        begin
                            if (bits_rem_reg != 5'd0)
                            begin
                                bits_rem_next = bits_rem_reg - 5'd1;
                                if (bits_rem_reg == 5'd1)
                                begin
                                    out_next.mosi_valid = 1'b1;
                                    out_next.mosi_byte  = shift_reg[7:0];
                                    rx_ctl.push         = 1'b1;
                                    rx_ctl.push_data    = capture & mask;
                                end
                            end
                            else if (!tx_empty)
                            begin
                                shift_next    = tx_head;
                                tx_ctl.pop    = 1'b1;
                                bits_rem_next = {1'b0, cr0_reg[3:0]} + 5'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    out_next = '0;
                end
            endcase
        end

        // Status outputs reflect the state after this operation
        out_next.irq_pending    = cr1_next[CR1_SSE] &&
                                  (((tx_cnt_next != CNT_W'(FIFO_DEPTH)) && imsc_next[RIS_TX]) ||
                                   ((rx_cnt_next != '0) && imsc_next[RIS_RX]));
        out_next.tx_dma_request = dmacr_next[DMA_TX] && (tx_cnt_next != CNT_W'(FIFO_DEPTH));
        out_next.rx_dma_request = dmacr_next[DMA_RX] && (rx_cnt_next != '0);
    end

    // Pushes and pops never meet in one FIFO in the same cycle
    always_comb
    begin
        tx_cnt_next = tx_count;
        if (tx_ctl.push && !tx_full)
            tx_cnt_next = tx_count + 1'b1;
        else if (tx_ctl.pop && !tx_empty)
            tx_cnt_next = tx_count - 1'b1;
        rx_cnt_next = rx_count;
        if (rx_ctl.push && !rx_full)
            rx_cnt_next = rx_count + 1'b1;
        else if (rx_ctl.pop && !rx_empty)
            rx_cnt_next = rx_count - 1'b1;
    end

    spm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_tx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tx_ctl),
        .head_data (tx_head),
        .count     (tx_count)
    );

    spm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rx_ctl),
        .head_data (rx_head),
        .count     (rx_count)
    );

    // Clamp the peripheral rate as it is written, so the first tick after a
    // write already sees the new step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_hz_reg  <= SYS_CLOCK_RESET;
            spi_hz_reg  <= SPI_CLOCK_RESET;
            add_amt_reg <= SPI_CLOCK_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_SYS_CLOCK)
            begin
                sys_hz_reg  <= cfg_data;
                add_amt_reg <= (spi_hz_reg < cfg_data) ? spi_hz_reg : cfg_data;
            end
            else
            begin
                spi_hz_reg  <= cfg_data;
                add_amt_reg <= (cfg_data < sys_hz_reg) ? cfg_data : sys_hz_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr0_reg       <= '0;
            cr1_reg       <= '0;
            cpsr_reg      <= '0;
            imsc_reg      <= '0;
            dmacr_reg     <= '0;
            accum_reg     <= '0;
            bitcnt_reg    <= '0;
            bits_rem_reg  <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cr0_reg      <= cr0_next;
            cr1_reg      <= cr1_next;
            cpsr_reg     <= cpsr_next;
            imsc_reg     <= imsc_next;
            dmacr_reg    <= dmacr_next;
            accum_reg    <= accum_next;
            bitcnt_reg   <= bitcnt_next;
            bits_rem_reg <= bits_rem_next;
            shift_reg    <= shift_next;
            if (exec)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
            out_item_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

FILE: verif/spm_checker.sv
// Checker for the serial master port: predicts one result per accepted request
// and compares it field by field with the block's output channel.
// Depends on spm_pkg for the payload types, offsets and bit positions.
module spm_checker (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_write,
    input  wire logic  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic  in_valid,
    input  wire logic  in_ready,
    input  spm_pkg::spm_in_t  in_item,
    input  wire logic  out_valid,
    input  wire logic  out_ready,
    input  spm_pkg::spm_out_t out_item,
    output int         fail_count,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    localparam int DEPTH     = FIFO_DEPTH_DEF;
    localparam int PRINT_CAP = 100;

    // Shadow copy of the port state
    logic [31:0] sys_hz;
    logic [31:0] spi_hz;
    logic [15:0] txq [DEPTH];
    logic [15:0] rxq [DEPTH];
    int unsigned tx_rd;
    int unsigned tx_level;
    int unsigned rx_rd;
    int unsigned rx_level;
    logic [31:0] cr0;
    logic [31:0] cr1;
    logic [7:0]  cpsr;
    logic [3:0]  imsc;
    logic [1:0]  dmacr;
    logic [63:0] accum;
    logic [15:0] bit_cyc;
    int unsigned bits_left;
    logic [15:0] shreg;

    spm_out_t expected_q [$];
    spm_out_t want;

    initial fail_count = 0;

    function automatic logic [15:0] frame_bits_mask();
        logic [16:0] m;
        m = (17'd1 << (cr0[3:0] + 5'd1)) - 17'd1;
        return m[15:0];
    endfunction

    function automatic logic [31:0] raw_irq();
        logic [31:0] r;
        r = '0;
        if (cr1[CR1_SSE])
        begin
            r[RIS_TX] = (tx_level < DEPTH);
            r[RIS_RX] = (rx_level != 0);
        end
        return r;
    endfunction

    function automatic spm_out_t serve_request(spm_in_t rq);
        spm_out_t    res;
        logic [31:0] add;
        logic [31:0] period;
        logic [15:0] cap;
        res = '0;
        case (rq.mode)
            MODE_READ:
                case (rq.offset)
                    OFF_CR0:   res.read_data = cr0;
                    OFF_CR1:   res.read_data = cr1;
                    OFF_DR:
                        if (rx_level != 0)
                        begin
                            res.read_data = {16'd0, rxq[rx_rd]};
                            rx_rd = (rx_rd + 1) % DEPTH;
                            rx_level--;
                        end
                    OFF_SR:
                    begin
                        res.read_data[SR_TFE] = (tx_level == 0);
                        res.read_data[SR_TNF] = (tx_level < DEPTH);
                        res.read_data[SR_RNE] = (rx_level != 0);
                        res.read_data[SR_RFF] = (rx_level >= DEPTH);
                        res.read_data[SR_BSY] = (tx_level != 0 || bits_left != 0);
                    end
                    OFF_CPSR:  res.read_data = {24'd0, cpsr};
                    OFF_IMSC:  res.read_data = {28'd0, imsc};
                    OFF_RIS:   res.read_data = raw_irq();
                    OFF_MIS:   res.read_data = raw_irq() & {28'd0, imsc};
                    OFF_DMACR: res.read_data = {30'd0, dmacr};
                    default:   res.read_data = '0;
                endcase
            MODE_WRITE:
                case (rq.offset)
                    OFF_CR0:   cr0 = rq.write_value;
                    OFF_CR1:   cr1 = rq.write_value;
                    OFF_DR:
                        if (tx_level < DEPTH)
                        begin
                            txq[(tx_rd + tx_level) % DEPTH] =
                                rq.write_value[15:0] & frame_bits_mask();
                            tx_level++;
                        end
                    OFF_CPSR:  cpsr = rq.write_value[7:0];
                    OFF_IMSC:  imsc = rq.write_value[3:0];
                    OFF_DMACR: dmacr = rq.write_value[1:0];
                    default: ;
                endcase
            MODE_TICK:
                if (cr1[CR1_SSE] && sys_hz != 0)
                begin
                    add = (spi_hz < sys_hz) ? spi_hz : sys_hz;
                    accum = accum + 64'(add);
                    if (accum >= 64'(sys_hz))
                    begin
                        accum = (accum - 64'(sys_hz)) & 64'h1_FFFF_FFFF;
                        if (cpsr < 8'd2 || cpsr[0])
                            period = 0;
                        else
                            period = 32'(cpsr) * (32'd1 + 32'(cr0[15:8]));
                        if (period != 0)
                        begin
                            bit_cyc = bit_cyc + 16'd1;
                            if (32'(bit_cyc) >= period)
                            begin
                                bit_cyc = '0;
                                if (bits_left > 0)
                                begin
                                    bits_left--;
                                    if (bits_left == 0)
                                    begin
                                        res.mosi_valid = 1'b1;
                                        res.mosi_byte  = shreg[7:0];
                                        if (cr1[CR1_LBM])
                                            cap = shreg;
                                        else if (rq.miso_valid)
                                            cap = rq.miso_word;
                                        else
                                            cap = 16'hFFFF;
                                        if (rx_level < DEPTH)
                                        begin
                                            rxq[(rx_rd + rx_level) % DEPTH] =
                                                cap & frame_bits_mask();
                                            rx_level++;
                                        end
                                    end
                                end
                                else if (tx_level != 0)
                                begin
                                    shreg = txq[tx_rd];
                                    tx_rd = (tx_rd + 1) % DEPTH;
                                    tx_level--;
                                    bits_left = cr0[3:0] + 1;
                                end
                            end
                        end
                    end
                end
            default: ;
        endcase
        res.irq_pending    = ((raw_irq() & {28'd0, imsc}) != 0);
        res.tx_dma_request = dmacr[DMA_TX] && (tx_level < DEPTH);
        res.rx_dma_request = dmacr[DMA_RX] && (rx_level != 0);
        return res;
    endfunction

    task automatic report(input string what);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("checker: %0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report($sformatf("%s got %h want %h", name, got, exp_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_hz    = SYS_CLOCK_RESET;
            spi_hz    = SPI_CLOCK_RESET;
            tx_rd     = 0;
            tx_level  = 0;
            rx_rd     = 0;
            rx_level  = 0;
            cr0       = '0;
            cr1       = '0;
            cpsr      = '0;
            imsc      = '0;
            dmacr     = '0;
            accum     = '0;
            bit_cyc   = '0;
            bits_left = 0;
            shreg     = '0;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_SYS_CLOCK)
                    sys_hz = cfg_data;
                else
                    spi_hz = cfg_data;
            end
            if (in_valid && in_ready)
                expected_q.insert(expected_q.size(), serve_request(in_item));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report("result with no request waiting");
                else
                begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    check_field("read_data", out_item.read_data, want.read_data);
                    check_field("mosi_valid", 32'(out_item.mosi_valid), 32'(want.mosi_valid));
                    check_field("mosi_byte", 32'(out_item.mosi_byte), 32'(want.mosi_byte));
                    check_field("irq_pending", 32'(out_item.irq_pending),
                                32'(want.irq_pending));
                    check_field("tx_dma_request", 32'(out_item.tx_dma_request),
                                32'(want.tx_dma_request));
                    check_field("rx_dma_request", 32'(out_item.rx_dma_request),
                                32'(want.rx_dma_request));
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// Top of the serial master port testbench: clock, reset, request stimulus,
// rate settings and the verdict. Depends on spm_pkg, spm_checker and the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    // Codes the package leaves unnamed: the spare mode, the clear register, a hole and an unaligned offset
    localparam logic [1:0]  MODE_SPARE = 2'd3;
    localparam logic [11:0] OFF_ICR    = 12'h020;
    localparam logic [11:0] OFF_HOLE   = 12'h028;
    localparam logic [11:0] OFF_SKEW   = 12'h002;

    localparam int RUN_LIMIT = 500000;
    localparam int PHASES    = 9;

    localparam logic [11:0] REG_OFFSETS [12] = '{
        OFF_CR0, OFF_CR1, OFF_DR, OFF_SR, OFF_CPSR, OFF_IMSC,
        OFF_RIS, OFF_MIS, OFF_ICR, OFF_DMACR, OFF_HOLE, OFF_SKEW
    };

    // Rate settings per phase: reset values, half rate, a dead peripheral clock,
    // a dead system clock, both at maximum, clamping, a rate just below the system
    // rate, a drop of the modulus below the accumulator, and back to reset values.
    localparam logic [31:0] SYS_RATES [PHASES] = '{
        32'd125000000, 32'd125000000, 32'd1, 32'd0, 32'hFFFF_FFFF,
        32'd1000, 32'd1000, 32'd3, 32'd125000000
    };
    localparam logic [31:0] SPI_RATES [PHASES] = '{
        32'd125000000, 32'd62500000, 32'd0, 32'd5, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'd999, 32'd3, 32'd125000000
    };
    localparam int PHASE_ITEMS [PHASES] = '{
        230, 230, 100, 100, 220, 200, 180, 200, 220
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    spm_in_t     in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    spm_out_t    out_item;

    int fail_count;
    int outstanding;

    int cycles        = 0;
    int stall_left    = 0;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int drain_pct     = 10;
    bit calm          = 1'b0;

    always #1ns clk = ~clk;

    spi_master_port_with_fifos_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    spm_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic int pick_idle_rate();
        case ($urandom_range(2, 0))
            0:       return 0;
            1:       return 6;
            default: return 30;
        endcase
    endfunction

    // Watchdog, idle-rate mood swings and the result-side stalls.
    // Periodically pick new idle rates, so that some stretches
    // run with no idling at all and others are heavy with it.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
        else
        begin
            if (cycles % 300 == 0)
            begin
                in_gap_pct    = pick_idle_rate();
                out_stall_pct = pick_idle_rate();
            end
            // Hold ready low for a burst of random length
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!calm && rst_n && $urandom_range(99, 0) < out_stall_pct)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(12, 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one request and hold it until the block takes it. An optional
    // idle gap of random length goes in front. The response word from the
    // attached device is random on every request.
    task automatic send(input logic [1:0] mode, input logic [11:0] offset,
                        input logic [31:0] value);
        spm_in_t rq;
        int      gap;
        rq.mode        = mode;
        rq.offset      = offset;
        rq.write_value = value;
        rq.miso_word   = 16'($urandom);
        rq.miso_valid  = 1'($urandom_range(1, 0));
        if (!calm && $urandom_range(99, 0) < in_gap_pct)
        begin
            gap = $urandom_range(13, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= rq;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic ticks(input int n);
        repeat (n) send(MODE_TICK, OFF_CR0, $urandom);
    endtask

    // Drop valid, let every expected result come home and the pipeline
    // settle, then write both rate registers.
    task automatic set_rates(input logic [31:0] sys_rate, input logic [31:0] spi_rate);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SYS_CLOCK;
        cfg_data  <= sys_rate;
        @(posedge clk);
        cfg_index <= CFG_SPI_CLOCK;
        cfg_data  <= spi_rate;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // One random request. Most of them are well-formed traffic that keeps
    // the port enabled with a running bit clock and frames in flight; the
    // rest is noise over the whole offset window and the spare mode.
    task automatic random_request();
        int          r;
        int          k;
        logic [31:0] v;
        logic [11:0] off;
        r = $urandom_range(99, 0);
        v = $urandom;
        if (r < 50)
            send(MODE_TICK, 12'($urandom), v);
        else if (r < 62)
            send(MODE_WRITE, OFF_DR, v);
        else if (r < 62 + drain_pct)
            send(MODE_READ, OFF_DR, v);
        else if (r < 78)
            send(MODE_READ, REG_OFFSETS[$urandom_range(11, 0)], v);
        else if (r < 88)
        begin
            case ($urandom_range(4, 0))
                0:
                begin
                    // Keep the clock divider short, and zero most of the time
                    v[15:8] = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(3, 1)) : 8'd0;
                    off = OFF_CR0;
                end
                1:
                begin
                    v[CR1_SSE] = ($urandom_range(99, 0) < 85);
                    off = OFF_CR1;
                end
                2:
                begin
                    k = $urandom_range(9, 0);
                    if (k < 7)
                        v[7:0] = 8'd2;
                    else if (k < 9)
                        v[7:0] = 8'd4;
                    off = OFF_CPSR;
                end
                3:       off = OFF_IMSC;
                default: off = OFF_DMACR;
            endcase
            send(MODE_WRITE, off, v);
        end
        else if (r < 95)
        begin
            off = $urandom_range(1, 0) ? 12'($urandom) : REG_OFFSETS[$urandom_range(11, 0)];
            send(2'($urandom_range(2, 0)), off, v);
        end
        else
            send(MODE_SPARE, 12'($urandom), v);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: reset status, empty reads, register extremes,
        // loopback and external frames, ignored writes, odd prescale,
        // unknown and unaligned offsets and the spare mode.
        send(MODE_READ, OFF_SR, '0);
        send(MODE_READ, OFF_RIS, '0);
        send(MODE_READ, OFF_DR, '0);
        send(MODE_WRITE, OFF_CR0, 32'hFFFF_FFFF);
        send(MODE_READ, OFF_CR0, '0);
        send(MODE_WRITE, OFF_CR0, 32'h0000_0000);
        send(MODE_WRITE, OFF_CR1, 32'h0000_0003);
        send(MODE_WRITE, OFF_CPSR, 32'h0000_0002);
        send(MODE_WRITE, OFF_IMSC, 32'hFFFF_FFFF);
        send(MODE_WRITE, OFF_DMACR, 32'hFFFF_FFFF);
        send(MODE_WRITE, OFF_DR, 32'hFFFF_FFFF);
        send(MODE_WRITE, OFF_DR, 32'h0000_0000);
        ticks(8);
        send(MODE_READ, OFF_DR, '0);
        send(MODE_READ, OFF_MIS, '0);
        send(MODE_WRITE, OFF_CR1, 32'h0000_0002);
        send(MODE_WRITE, OFF_DR, 32'h0000_0001);
        ticks(4);
        send(MODE_WRITE, OFF_ICR, 32'hFFFF_FFFF);
        send(MODE_WRITE, OFF_SR, 32'hFFFF_FFFF);
        send(MODE_WRITE, OFF_CPSR, 32'h0000_00FF);
        ticks(2);
        send(MODE_SPARE, 12'hFFF, 32'hFFFF_FFFF);
        send(MODE_READ, 12'hFFF, '0);
        send(MODE_READ, OFF_SKEW, '0);
        send(MODE_WRITE, OFF_CPSR, 32'h0000_0002);

        // Random phases, each under its own rate setting. Some phases rarely
        // read the receive data so that both FIFOs run full.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
                set_rates(SYS_RATES[p], SPI_RATES[p]);
            calm      = (p == PHASES - 1);
            drain_pct = ($urandom_range(1, 0) || calm) ? 10 : 1;
            repeat (PHASE_ITEMS[p]) random_request();
        end

        // Drain: wait for the last results, then keep the clock running so that
        // any stray output would be seen.
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
